// ===== design/sbsm_pkg.sv =====
// Shared types and constants for the serial bank-switch mapper.
`timescale 1ns / 1ps
`default_nettype none
package sbsm_pkg;

  typedef enum logic [2:0] {
    TGT_CHR     = 3'd0,
    TGT_PRG_RAM = 3'd1,
    TGT_PRG_ROM = 3'd2,
    TGT_REG     = 3'd3,
    TGT_NONE    = 3'd4
  } target_t;

  localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG = 2'd3;

  localparam logic CFG_IDX_BANK_COUNT = 1'b0;
  localparam logic CFG_IDX_START_VERT = 1'b1;

  localparam logic [4:0] BANK_COUNT_RESET = 5'd16;
  localparam logic [2:0] SERIAL_LAST = 3'd4;
  localparam int PADDR_W = 3;

  typedef struct packed {
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [3:0] prg_bank_low;
    logic [3:0] prg_bank_high;
  } bank_sel_t;

  typedef struct packed {
    logic       we;
    logic [1:0] sel;
    logic [7:0] data;
  } ser_wr_t;

endpackage
`default_nettype wire

// ===== design/sbsm_bank_regs.sv =====
// Serial shift register, bank select registers and configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module sbsm_bank_regs
  import sbsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ser_wr_t    ser_wr,
  input  wire logic       cfg_we,
  input  wire logic       cfg_idx,
  input  wire logic [4:0] cfg_wdata,
  output bank_sel_t       banks,
  output logic [4:0]      prg_bank_count,
  output logic            start_vertical,
  output logic [1:0]      mirror_nxt
);

  logic [4:0] serial_value_r, serial_value_nxt;
  logic [2:0] serial_count_r, serial_count_nxt;
  logic [1:0] mirroring_r;
  logic       prg_swap_r, prg_swap_nxt;
  logic       prg_small_r, prg_small_nxt;
  logic       chr_small_r, chr_small_nxt;
  bank_sel_t  banks_r, banks_nxt;
  logic [4:0] bank_count_r, bank_count_nxt;
  logic       start_vert_r, start_vert_nxt;
  logic [4:0] shifted;
  logic [3:0] last_bank;
  logic [3:0] pair_base;

  assign shifted   = {ser_wr.data[0], serial_value_r[4:1]};
  assign last_bank = bank_count_r[3:0] - 4'd1;
  assign pair_base = {shifted[3:1], 1'b0};

  always_comb begin
    serial_value_nxt = serial_value_r;
    serial_count_nxt = serial_count_r;
    mirror_nxt       = mirroring_r;
    prg_swap_nxt     = prg_swap_r;
    prg_small_nxt    = prg_small_r;
    chr_small_nxt    = chr_small_r;
    banks_nxt        = banks_r;
    bank_count_nxt   = bank_count_r;
    start_vert_nxt   = start_vert_r;
    if (cfg_we) begin
      if (cfg_idx == CFG_IDX_BANK_COUNT) begin
        bank_count_nxt          = cfg_wdata;
        banks_nxt.prg_bank_high = cfg_wdata[3:0] - 4'd1;
      end else begin
        start_vert_nxt = cfg_wdata[0];
        mirror_nxt     = cfg_wdata[0] ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
      end
    end else if (ser_wr.we) begin
      if (ser_wr.data[7]) begin
        serial_value_nxt = '0;
        serial_count_nxt = '0;
      end else if (serial_count_r != SERIAL_LAST) begin
        serial_value_nxt = shifted;
        serial_count_nxt = serial_count_r + 3'd1;
      end else begin
        serial_value_nxt = '0;
        serial_count_nxt = '0;
        unique case (ser_wr.sel)
          SEL_CONTROL: begin
            mirror_nxt    = shifted[1:0];
            prg_swap_nxt  = shifted[2];
            prg_small_nxt = shifted[3];
            chr_small_nxt = shifted[4];
          end
          SEL_CHR_LOW: begin
            if (!chr_small_r) begin
              banks_nxt.chr_bank_low  = {shifted[4:1], 1'b0};
              banks_nxt.chr_bank_high = {shifted[4:1], 1'b1};
            end else begin
              banks_nxt.chr_bank_low = shifted;
            end
          end
          SEL_CHR_HIGH: begin
            if (chr_small_r) begin
              banks_nxt.chr_bank_high = shifted;
            end
          end
          SEL_PRG: begin
            if (!prg_small_r) begin
              banks_nxt.prg_bank_low  = pair_base;
              banks_nxt.prg_bank_high = {pair_base[3:1], 1'b1};
            end else if (!prg_swap_r) begin
              banks_nxt.prg_bank_low  = '0;
              banks_nxt.prg_bank_high = shifted[3:0];
            end else begin
              banks_nxt.prg_bank_low  = shifted[3:0];
              banks_nxt.prg_bank_high = last_bank;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serial_value_r <= '0;
      serial_count_r <= '0;
      mirroring_r    <= MIRROR_HORIZONTAL;
      prg_swap_r     <= 1'b0;
      prg_small_r    <= 1'b0;
      chr_small_r    <= 1'b0;
      banks_r        <= '{chr_bank_low: 5'd0, chr_bank_high: 5'd0,
                          prg_bank_low: 4'd0,
                          prg_bank_high: BANK_COUNT_RESET[3:0] - 4'd1};
      bank_count_r   <= BANK_COUNT_RESET;
      start_vert_r   <= 1'b0;
    end else begin
      serial_value_r <= serial_value_nxt;
      serial_count_r <= serial_count_nxt;
      mirroring_r    <= mirror_nxt;
      prg_swap_r     <= prg_swap_nxt;
      prg_small_r    <= prg_small_nxt;
      chr_small_r    <= chr_small_nxt;
      banks_r        <= banks_nxt;
      bank_count_r   <= bank_count_nxt;
      start_vert_r   <= start_vert_nxt;
    end
  end

  assign banks          = banks_r;
  assign prg_bank_count = bank_count_r;
  assign start_vertical = start_vert_r;

endmodule
`default_nettype wire

// ===== design/serial_bank_switch_mapper_core.sv =====
// Top level of the serial bank-switch mapper: address translation and result register.
//
// Usage: each input transaction (in_kind, in_address, in_write_data) is one bus
// access. The result transaction gives out_target, the translated out_mem_address,
// the out_mem_write strobe and out_mirror_mode as it stands after the access.
// Writes at 0x8000 and above go to the serial shift register; the fifth bit
// loads the register chosen by address bits 14-13.
// out_valid rises in the cycle after input acceptance. Throughput: one
// transaction per cycle; the single result register sets this, and in_ready
// stays high while that register is empty or being drained.
// Stall: if out_ready is low while a result is held, in_ready drops and the
// held result stays stable until taken.
// Reset (rst_n low, synchronous): serial register and bank selections clear,
// the high PRG bank becomes the last bank, mirroring goes horizontal, and the
// configuration registers return to a bank count of 16 and start_vertical 0.
// Configuration (APB, pready always high) must be written only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module serial_bank_switch_mapper_core
  import sbsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [15:0]        in_address,
  input  wire logic [7:0]         in_write_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_target,
  output logic [17:0]             out_mem_address,
  output logic                    out_mem_write,
  output logic [1:0]              out_mirror_mode,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic        accept;
  logic        cfg_we;
  ser_wr_t     ser_wr;
  bank_sel_t   banks;
  logic [4:0]  bank_count;
  logic        start_vert;
  logic [1:0]  mirror_nxt;
  target_t     target_nxt;
  logic [17:0] maddr_nxt;
  logic        mw_nxt;
  logic [4:0]  chr_bank;
  logic [3:0]  prg_bank;

  logic        out_valid_r;
  target_t     target_r;
  logic [17:0] maddr_r;
  logic        mw_r;
  logic [1:0]  mirror_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;

  assign ser_wr.we   = accept && in_kind && in_address[15];
  assign ser_wr.sel  = in_address[14:13];
  assign ser_wr.data = in_write_data;

  sbsm_bank_regs u_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .ser_wr         (ser_wr),
    .cfg_we         (cfg_we),
    .cfg_idx        (paddr[2]),
    .cfg_wdata      (pwdata[4:0]),
    .banks          (banks),
    .prg_bank_count (bank_count),
    .start_vertical (start_vert),
    .mirror_nxt     (mirror_nxt)
  );

  always_comb begin
    if (paddr[2] == CFG_IDX_BANK_COUNT) begin
      prdata = {27'd0, bank_count};
    end else begin
      prdata = {31'd0, start_vert};
    end
  end

  assign chr_bank = in_address[12] ? banks.chr_bank_high : banks.chr_bank_low;
  assign prg_bank = in_address[14] ? banks.prg_bank_high : banks.prg_bank_low;

  always_comb begin
    target_nxt = TGT_NONE;
    maddr_nxt  = '0;
    mw_nxt     = 1'b0;
    priority if (in_address[15:13] == 3'b000) begin
      target_nxt = TGT_CHR;
      maddr_nxt  = {1'b0, chr_bank, in_address[11:0]};
      mw_nxt     = in_kind;
    end else if (in_address[15:13] == 3'b011) begin
      target_nxt = TGT_PRG_RAM;
      maddr_nxt  = {5'd0, in_address[12:0]};
      mw_nxt     = in_kind;
    end else if (!in_address[15]) begin
      target_nxt = TGT_NONE;
    end else if (!in_kind) begin
      target_nxt = TGT_PRG_ROM;
      maddr_nxt  = {prg_bank, in_address[13:0]};
    end else begin
      target_nxt = TGT_REG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target_r <= target_nxt;
      maddr_r  <= maddr_nxt;
      mw_r     <= mw_nxt;
      mirror_r <= mirror_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_target      = target_r;
  assign out_mem_address = maddr_r;
  assign out_mem_write   = mw_r;
  assign out_mirror_mode = mirror_r;

endmodule
`default_nettype wire

// ===== design/sbsm_checker.sv =====
// Port-level assertions for the serial bank-switch mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbsm_checker
  import sbsm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_target,
  input wire logic [17:0] out_mem_address,
  input wire logic        out_mem_write
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target)
      && $stable(out_mem_address) && $stable(out_mem_write))
    else $error("result changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result slot");

  a_no_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_target == TGT_NONE || out_target == TGT_REG)
      |-> out_mem_address == 18'd0 && !out_mem_write)
    else $error("memory access on unmapped or register transaction");

  a_rom_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target == TGT_PRG_ROM |-> !out_mem_write)
    else $error("write strobe on program ROM");

endmodule

bind serial_bank_switch_mapper_core sbsm_checker u_sbsm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_target      (out_target),
  .out_mem_address (out_mem_address),
  .out_mem_write   (out_mem_write)
);
`default_nettype wire
